// ===== hdl/gsl_pkg.sv =====
// Package for the GIF stream length detector: transaction types, register map
// and reset constants. No dependencies.
package gsl_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned MinLenW           = 11;
  localparam int unsigned CfgAddrW          = 2;
  localparam int unsigned CfgDataW          = 32;
  localparam int unsigned FileLenW          = 32;

  localparam logic [MinLenW-1:0]  MinLengthReset = 11'd14;
  localparam logic [CfgAddrW-1:0] AddrMinLength  = 2'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic                is_gif;
    logic [FileLenW-1:0] file_length;
  } result_t;

endpackage

// ===== hdl/gsl_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
// Payload type comes from gsl_pkg at the instantiation site.
interface gsl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/gsl_cfg_regs.sv =====
// APB-style configuration register file holding min_length.
// Depends on gsl_pkg.
module gsl_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gsl_pkg::CfgAddrW-1:0]   paddr,
  input  logic [gsl_pkg::CfgDataW-1:0]   pwdata,
  output logic [gsl_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  output logic [gsl_pkg::MinLenW-1:0]    min_length_o
);

  logic [gsl_pkg::MinLenW-1:0] min_length_q;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == gsl_pkg::AddrMinLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= gsl_pkg::MinLengthReset;
    end else if (wr_en) begin
      min_length_q <= pwdata[gsl_pkg::MinLenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == gsl_pkg::AddrMinLength) begin
      prdata = {{(gsl_pkg::CfgDataW - gsl_pkg::MinLenW){1'b0}}, min_length_q};
    end
  end

  assign min_length_o = min_length_q;

endmodule

// ===== hdl/gsl_parser.sv =====
// Block-structure walker: updates parse state for one byte per step and
// forms the verdict on the last byte. Depends on gsl_pkg.
module gsl_parser #(
  parameter int unsigned LengthBits = gsl_pkg::LengthBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  gsl_pkg::item_t              item_i,
  input  logic [gsl_pkg::MinLenW-1:0] min_length_i,
  output logic                        res_valid_o,
  output gsl_pkg::result_t            res_o
);

  localparam int unsigned CntW = (LengthBits > 32) ? 32 : LengthBits;
  localparam logic [CntW-1:0] SeenMax = '1;

  typedef enum logic [3:0] {
    PhHeader, PhGtable, PhMarker, PhDesc, PhLtable,
    PhCodesize, PhExtlabel, PhSubsize, PhSubdata, PhDone
  } phase_e;

  typedef enum logic [1:0] {
    OcPending, OcAccept, OcReject
  } outcome_e;

  phase_e          phase_q, phase_d, phase_n;
  outcome_e        outcome_q, outcome_d, outcome_n;
  logic [CntW-1:0] seen_q, seen_d, seen_n;
  logic [CntW-1:0] found_q, found_d, found_n;
  logic [3:0]      fidx_q, fidx_d, fidx_n;
  logic [9:0]      skip_q, skip_d, skip_n;
  logic [7:0]      b;
  logic [9:0]      tbl_bytes;
  logic            sig_ok;
  logic            ok;

  assign b         = item_i.data_byte;
  assign tbl_bytes = (10'd2 << b[2:0]) + (10'd4 << b[2:0]);

  always_comb begin
    phase_n   = phase_q;
    outcome_n = outcome_q;
    seen_n    = seen_q;
    found_n   = found_q;
    fidx_n    = fidx_q;
    skip_n    = skip_q;
    sig_ok    = 1'b1;

    if (outcome_q == OcPending) begin
      if (seen_q == SeenMax) begin
        outcome_n = OcReject;
      end else begin
        case (phase_q)
          PhHeader: begin
            case (fidx_q)
              4'd0:  sig_ok = (b == 8'h47);
              4'd1:  sig_ok = (b == 8'h49);
              4'd2:  sig_ok = (b == 8'h46);
              4'd3:  sig_ok = (b == 8'h38);
              4'd4:  sig_ok = b inside {8'h37, 8'h39};
              4'd5:  sig_ok = (b == 8'h61);
              4'd10: skip_n = b[7] ? tbl_bytes : 10'd0;
              default: sig_ok = 1'b1;
            endcase
            if (!sig_ok) begin
              outcome_n = OcReject;
            end else if (fidx_q >= 4'd12) begin
              fidx_n  = '0;
              phase_n = (skip_n != 10'd0) ? PhGtable : PhMarker;
            end else begin
              fidx_n = fidx_q + 4'd1;
            end
          end
          PhGtable, PhLtable, PhSubdata: begin
            if (skip_q != 10'd0) begin
              skip_n = skip_q - 10'd1;
            end
            if (skip_n == 10'd0) begin
              phase_n = (phase_q == PhGtable) ? PhMarker
                      : (phase_q == PhLtable) ? PhCodesize : PhSubsize;
            end
          end
          PhMarker: begin
            if (b == 8'h2C) begin
              fidx_n  = '0;
              phase_n = PhDesc;
            end else if (b == 8'h21) begin
              phase_n = PhExtlabel;
            end else if (b == 8'h3B) begin
              outcome_n = OcAccept;
              found_n   = seen_q + CntW'(1);
              phase_n   = PhDone;
            end else begin
              outcome_n = OcReject;
            end
          end
          PhDesc: begin
            if (fidx_q >= 4'd8) begin
              fidx_n = '0;
              if (b[7]) begin
                skip_n  = tbl_bytes;
                phase_n = PhLtable;
              end else begin
                phase_n = PhCodesize;
              end
            end else begin
              fidx_n = fidx_q + 4'd1;
            end
          end
          PhCodesize, PhExtlabel: phase_n = PhSubsize;
          PhSubsize: begin
            if (b == 8'h00) begin
              phase_n = PhMarker;
            end else begin
              skip_n  = {2'b00, b};
              phase_n = PhSubdata;
            end
          end
          default: phase_n = phase_q;
        endcase
      end
    end

    if (seen_q != SeenMax) begin
      seen_n = seen_q + CntW'(1);
    end

    ok = (outcome_n == OcAccept) &&
         (seen_n >= {{(CntW - gsl_pkg::MinLenW){1'b0}}, min_length_i});

    phase_d   = phase_q;
    outcome_d = outcome_q;
    seen_d    = seen_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    skip_d    = skip_q;
    if (step_i) begin
      if (item_i.last_byte) begin
        phase_d   = PhHeader;
        outcome_d = OcPending;
        seen_d    = '0;
        found_d   = '0;
        fidx_d    = '0;
        skip_d    = '0;
      end else begin
        phase_d   = phase_n;
        outcome_d = outcome_n;
        seen_d    = seen_n;
        found_d   = found_n;
        fidx_d    = fidx_n;
        skip_d    = skip_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      outcome_q <= OcPending;
      seen_q    <= '0;
      found_q   <= '0;
      fidx_q    <= '0;
      skip_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      outcome_q <= outcome_d;
      seen_q    <= seen_d;
      found_q   <= found_d;
      fidx_q    <= fidx_d;
      skip_q    <= skip_d;
    end
  end

  assign res_valid_o        = step_i && item_i.last_byte;
  assign res_o.is_gif       = ok;
  assign res_o.file_length  = ok ? {{(gsl_pkg::FileLenW - CntW){1'b0}}, found_n}
                                 : '0;

endmodule

// ===== hdl/gif_stream_length_detector.sv =====
// GIF stream length detector: one byte per cycle sustained, back to back.
// The result passes the input register, then the parser into the result
// register; a held result stalls only a following last byte. Reset (rst_ni
// low, async) empties both registers, clears the parse state and sets
// min_length to 14.
// Depends on gsl_pkg, gsl_stream_if, gsl_cfg_regs and gsl_parser.
module gif_stream_length_detector #(
  parameter int unsigned LengthBits = gsl_pkg::LengthBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gsl_stream_if.sink                   byte_i,
  gsl_stream_if.source                 result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsl_pkg::CfgAddrW-1:0] paddr,
  input  logic [gsl_pkg::CfgDataW-1:0] pwdata,
  output logic [gsl_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);

  logic                        in_vld_q;
  gsl_pkg::item_t              in_item_q;
  logic                        out_vld_q;
  gsl_pkg::result_t            out_res_q;
  logic                        advance;
  logic                        load;
  logic                        res_valid;
  gsl_pkg::result_t            res;
  logic [gsl_pkg::MinLenW-1:0] min_length;

  gsl_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .min_length_o (min_length)
  );

  assign advance = in_vld_q && (!in_item_q.last_byte || !out_vld_q || result_o.ready);
  assign byte_i.ready = !in_vld_q || advance;
  assign load = byte_i.valid && byte_i.ready;

  gsl_parser #(
    .LengthBits (LengthBits)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .min_length_i (min_length),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (res_valid) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= byte_i.payload;
    end
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid   = out_vld_q;
  assign result_o.payload = out_res_q;

endmodule
